[sv/addressed_frame_deframer_assert.svh]
// Assertion helpers used by the file that checks this block.
`ifndef ADDRESSED_FRAME_DEFRAMER_ASSERT_SVH
`define ADDRESSED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afd check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afd check failed");

`endif

[sv/afd_pkg.sv]
package afd_pkg;

    localparam int unsigned NUM_SOURCES = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_DEST,
        PH_SRC,
        PH_FUNC,
        PH_LEN1,
        PH_LEN2,
        PH_DATA,
        PH_SUM
    } afd_phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } afd_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER  = 2'd0,
        CFG_HOST    = 2'd1,
        CFG_SOURCES = 2'd2
    } afd_cfg_index_t;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  host_address;
        logic [63:0] known_sources;
    } afd_cfg_t;

    typedef struct packed {
        afd_kind_t  kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] source_address;
        logic [7:0] function_code;
        logic [7:0] payload_length;
    } afd_result_t;

endpackage

[sv/afd_in_if.sv]
interface afd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[sv/afd_out_if.sv]
interface afd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] source_address;
    logic [7:0] function_code;
    logic [7:0] payload_length;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output source_address, output function_code, output payload_length,
        input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input source_address, input function_code, input payload_length,
        output ready
    );
endinterface

[sv/afd_cfg_regs.sv]
module afd_cfg_regs
    import afd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output afd_cfg_t               cfg
);

    afd_cfg_t cfg_reg;
    afd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER:  cfg_next.header_byte   = cfg_data[7:0];
                CFG_HOST:    cfg_next.host_address  = cfg_data[7:0];
                CFG_SOURCES: cfg_next.known_sources = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/afd_in_stage.sv]
module afd_in_stage
    import afd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    afd_in_if.sink      in_ch,
    input  logic        advance,
    output logic        held_valid,
    output logic [7:0]  held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // The register refills whenever it is empty or its item moves on this cycle.
    assign in_ch.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (in_ch.ready)
        begin
            valid_next = in_ch.valid;
            byte_next  = in_ch.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

[sv/afd_parser.sv]
module afd_parser
    import afd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  afd_cfg_t    cfg,
    input  logic        take,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output afd_result_t res
);

    afd_phase_t phase_reg;
    afd_phase_t phase_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] src_reg;
    logic [7:0] src_next;
    logic [7:0] func_reg;
    logic [7:0] func_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;
    logic       src_known;
    logic [8:0] cnt_plus;

    always_comb
    begin
        src_known = 1'b0;
        for (int k = 0; k < NUM_SOURCES; k++)
        begin
            if (cfg.known_sources[8*k +: 8] == rx_byte)
            begin
                src_known = 1'b1;
            end
        end
    end

    assign cnt_plus = {1'b0, cnt_reg} + 9'd1;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        src_next   = src_reg;
        func_next  = func_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        res_valid  = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = 8'h00;
        res.payload_index  = 8'h00;
        res.source_address = src_reg;
        res.function_code  = func_reg;
        res.payload_length = len_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == cfg.header_byte)
                    begin
                        phase_next = PH_DEST;
                    end
                end
                PH_DEST:
                begin
                    if (rx_byte == cfg.host_address)
                    begin
                        sum_next   = rx_byte;
                        phase_next = PH_SRC;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SRC:
                begin
                    if (src_known)
                    begin
                        src_next   = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_FUNC;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_FUNC:
                begin
                    func_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    // The first length byte only counts toward the checksum.
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LEN2;
                end
                PH_LEN2:
                begin
                    len_next   = rx_byte;
                    cnt_next   = 8'h00;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = (rx_byte == 8'h00) ? PH_SUM : PH_DATA;
                end
                PH_DATA:
                begin
                    sum_next          = sum_reg + rx_byte;
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.payload_index = cnt_reg;
                    if (cnt_plus >= {1'b0, len_reg})
                    begin
                        phase_next = PH_SUM;
                    end
                    else
                    begin
                        cnt_next = cnt_plus[7:0];
                    end
                end
                PH_SUM:
                begin
                    res_valid  = 1'b1;
                    res.kind   = (rx_byte == sum_reg) ? KIND_GOOD : KIND_BAD;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'h00;
            src_reg   <= 8'h00;
            func_reg  <= 8'h00;
            len_reg   <= 8'h00;
            cnt_reg   <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            src_reg   <= src_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[sv/afd_out_stage.sv]
module afd_out_stage
    import afd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    input  afd_result_t load_res,
    output logic        advance,
    afd_out_if.source   out_ch
);

    logic        valid_reg;
    logic        valid_next;
    afd_result_t res_reg;
    afd_result_t res_next;

    // The stage moves on when its slot is empty or the sink takes the held item.
    assign advance = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (advance)
        begin
            valid_next = load_valid;
            res_next   = load_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.result_kind    = res_reg.kind;
    assign out_ch.payload_byte   = res_reg.payload_byte;
    assign out_ch.payload_index  = res_reg.payload_index;
    assign out_ch.source_address = res_reg.source_address;
    assign out_ch.function_code  = res_reg.function_code;
    assign out_ch.payload_length = res_reg.payload_length;

endmodule

[sv/addressed_frame_deframer.sv]
// Bytes pass from the input register through the parser into the result register.
// Throughput: one byte per cycle unless the output sink stalls; the input and result
// registers are the only stages, and the parser steps its phase once per byte.
// Reset (rst_n, asynchronous, active low) zeroes the config and parser registers, sets
// the parser to header hunting, and both stages to empty. No clearing pass is needed.
`include "addressed_frame_deframer_assert.svh"

module addressed_frame_deframer
    import afd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    afd_in_if.sink                 in_ch,
    afd_out_if.source              out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    afd_cfg_t    cfg;
    logic        advance;
    logic        held_valid;
    logic [7:0]  held_byte;
    logic        take;
    logic        res_valid;
    afd_result_t res;

    afd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    assign take = held_valid && advance;

    afd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .take      (take),
        .rx_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    afd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (take && res_valid),
        .load_res   (res),
        .advance    (advance),
        .out_ch     (out_ch)
    );

    `AFD_ASSERT_SAME(a_end_fields_zero, clk, rst_n,
        out_ch.valid && (out_ch.result_kind != KIND_PAYLOAD),
        (out_ch.payload_byte == 8'h00) && (out_ch.payload_index == 8'h00))
    `AFD_ASSERT_SAME(a_index_in_length, clk, rst_n,
        out_ch.valid && (out_ch.result_kind == KIND_PAYLOAD),
        out_ch.payload_index < out_ch.payload_length)
    `AFD_ASSERT_SAME(a_full_blocks_input, clk, rst_n,
        held_valid && out_ch.valid && !out_ch.ready, !in_ch.ready)
    `AFD_ASSERT_NEXT(a_result_loaded, clk, rst_n,
        take && res_valid, out_ch.valid)

endmodule
